@@ rtl/rmfs_pkg.sv @@
// Package for the range most-frequent block: field widths, input mode codes,
// controller states and the command and status structs.
// No dependencies.
package rmfs_pkg;

    // Fixed widths of the stream fields.
    localparam int VALUE_W    = 32;
    localparam int POS_W      = 11;
    localparam int FREQ_W     = 11;
    localparam int S_TDATA_W  = 56;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 16;
    localparam int M_TUSER_W  = 1;

    // Mode codes carried on the input tuser.
    typedef enum logic [1:0] {
        MODE_CLEAR  = 2'd0,
        MODE_APPEND = 2'd1,
        MODE_BUILD  = 2'd2,
        MODE_QUERY  = 2'd3
    } mode_t;

    // Controller states.
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_APPEND,
        ST_BLD_RDA,
        ST_BLD_RDB,
        ST_BLD_WR,
        ST_BLD_DONE,
        ST_Q_L,
        ST_Q_R,
        ST_Q_RS,
        ST_Q_RS2,
        ST_Q_B,
        ST_Q_OUT,
        ST_Q_INV
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic latch;
        logic clear;
        logic append;
        logic bld_init;
        logic bld_rd_a;
        logic bld_rd_b;
        logic bld_wr;
        logic bld_done;
        logic q_rd_l;
        logic q_rd_r;
        logic q_rd_rs;
        logic q_rd_rs2;
        logic q_rd_b;
        logic q_out;
        logic q_invalid;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic q_ok;
        logic bld_empty;
        logic bld_last;
        logic out_free;
    } status_t;

endpackage

@@ rtl/range_most_frequent_sorted_top.sv @@
// Append and clear: taken in idle, then one command state acts. Query: states L, R,
// RS, RS2 and B follow the chain of dependent registered memory reads, then OUT loads
// the result register; a rejected query takes INV instead. Build: table entries above
// level zero each get read A, read B and write via the sparse table's single read port.
// One item is in work at a time; a result may wait while the next item is taken.
// Synchronous active-low reset clears the counters and table flag; no memory clearing.
module range_most_frequent_sorted_top #(
    parameter int MAX_ITEMS = 1024,
    parameter int LEVELS    = 11
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // value [31:0], left_position [42:32], right_position [53:43]
    input  logic [rmfs_pkg::S_TDATA_W-1:0] s_tdata,
    // mode [1:0]
    input  logic [rmfs_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // max_frequency [10:0]
    output logic [rmfs_pkg::M_TDATA_W-1:0] m_tdata,
    // invalid [0]
    output logic [rmfs_pkg::M_TUSER_W-1:0] m_tuser
);
    import rmfs_pkg::*;

    cmd_t              cmd;
    status_t           status;
    mode_t             mode;
    logic [FREQ_W-1:0] freq;
    logic              inv;

    // Unpack the input item.
    assign mode = mode_t'(s_tuser);

    rmfs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .mode     (mode),
        .status   (status),
        .cmd      (cmd)
    );

    rmfs_dp #(.MAX_ITEMS(MAX_ITEMS), .LEVELS(LEVELS)) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .value          (s_tdata[31:0]),
        .left_position  (s_tdata[42:32]),
        .right_position (s_tdata[53:43]),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .max_frequency  (freq),
        .invalid        (inv)
    );

    // Pack the result item.
    assign m_tdata = M_TDATA_W'(freq);
    assign m_tuser = inv;

endmodule

@@ rtl/rmfs_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module rmfs_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/rmfs_ctrl.sv @@
// Controller state machine: sequences clear, append, table build and query.
// Depends on rmfs_pkg.
module rmfs_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  rmfs_pkg::mode_t  mode,
    input  rmfs_pkg::status_t status,
    output rmfs_pkg::cmd_t   cmd
);
    import rmfs_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch = 1'b1;
                    unique case (mode)
                        MODE_CLEAR:  state_next = ST_CLEAR;
                        MODE_APPEND: state_next = ST_APPEND;
                        MODE_BUILD: begin
                            cmd.bld_init = 1'b1;
                            state_next   = status.bld_empty ? ST_BLD_DONE : ST_BLD_RDA;
                        end
                        MODE_QUERY:  state_next = status.q_ok ? ST_Q_L : ST_Q_INV;
                        default:     state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                cmd.clear  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_APPEND: begin
                cmd.append = 1'b1;
                state_next = ST_IDLE;
            end
            ST_BLD_RDA: begin
                cmd.bld_rd_a = 1'b1;
                state_next   = ST_BLD_RDB;
            end
            ST_BLD_RDB: begin
                cmd.bld_rd_b = 1'b1;
                state_next   = ST_BLD_WR;
            end
            ST_BLD_WR: begin
                cmd.bld_wr = 1'b1;
                state_next = status.bld_last ? ST_BLD_DONE : ST_BLD_RDA;
            end
            ST_BLD_DONE: begin
                cmd.bld_done = 1'b1;
                state_next   = ST_IDLE;
            end
            ST_Q_L: begin
                cmd.q_rd_l = 1'b1;
                state_next = ST_Q_R;
            end
            ST_Q_R: begin
                cmd.q_rd_r = 1'b1;
                state_next = ST_Q_RS;
            end
            ST_Q_RS: begin
                cmd.q_rd_rs = 1'b1;
                state_next  = ST_Q_RS2;
            end
            ST_Q_RS2: begin
                cmd.q_rd_rs2 = 1'b1;
                state_next   = ST_Q_B;
            end
            ST_Q_B: begin
                cmd.q_rd_b = 1'b1;
                state_next = ST_Q_OUT;
            end
            ST_Q_OUT: begin
                cmd.q_out = 1'b1;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            ST_Q_INV: begin
                cmd.q_invalid = 1'b1;
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

@@ rtl/rmfs_dp.sv @@
// Datapath: list counters, run memories, sparse table, query arithmetic and
// the result register. Depends on rmfs_pkg and rmfs_ram.
module rmfs_dp #(
    parameter int MAX_ITEMS = 1024,
    parameter int LEVELS    = 11
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  rmfs_pkg::cmd_t               cmd,
    output rmfs_pkg::status_t            status,
    input  logic [rmfs_pkg::VALUE_W-1:0] value,
    input  logic [rmfs_pkg::POS_W-1:0]   left_position,
    input  logic [rmfs_pkg::POS_W-1:0]   right_position,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [rmfs_pkg::FREQ_W-1:0]  max_frequency,
    output logic                         invalid
);
    import rmfs_pkg::*;

    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int LW = $clog2(LEVELS);
    localparam int TW = LW + AW;

    // Leading-one position of a run distance.
    function automatic int floor_log2(input logic [AW-1:0] x);
        int k;
        k = 0;
        for (int b = 0; b < AW; b++) begin
            if (x[b]) begin
                k = b;
            end
        end
        return k;
    endfunction

    logic [VALUE_W-1:0] value_reg;
    logic [AW-1:0]      l_reg;
    logic [AW-1:0]      r_reg;
    logic [VALUE_W-1:0] last_value_reg;
    logic [CW-1:0]      item_count_reg;
    logic [CW-1:0]      run_count_reg;
    logic [CW-1:0]      run_len_reg;
    logic               built_reg;
    logic [LW-1:0]      k_reg;
    logic [AW-1:0]      i_reg;
    logic [CW-1:0]      a_reg;
    logic [AW-1:0]      li_reg;
    logic [AW-1:0]      ri_reg;
    logic [AW-1:0]      rs_reg;
    logic [AW-1:0]      rs2_reg;
    logic [LW-1:0]      m_reg;
    logic               m_tvalid_reg;
    logic [FREQ_W-1:0]  freq_reg;
    logic               inv_reg;

    logic               rop_we;
    logic [AW-1:0]      rop_raddr;
    logic [AW-1:0]      rop_rdata;
    logic               rs_we;
    logic [AW-1:0]      rs_raddr;
    logic [AW-1:0]      rs_rdata;
    logic               st_we;
    logic [TW-1:0]      st_waddr;
    logic [CW-1:0]      st_wdata;
    logic [TW-1:0]      st_raddr;
    logic [CW-1:0]      st_rdata;

    logic               full;
    logic               new_run;
    logic [AW-1:0]      run_idx;
    logic [CW-1:0]      len_next;
    logic               has_b;
    logic [AW-1:0]      i_half;
    logic [LW-1:0]      m_sel;
    logic [AW-1:0]      run_gap;
    logic [CW-1:0]      best;
    logic [CW-1:0]      e_right;
    logic [CW-1:0]      e_left;
    logic [CW-1:0]      mid;
    logic               out_free;

    // Status toward the controller.
    assign out_free = !m_tvalid_reg || m_tready;
    always_comb begin
        status.q_ok = built_reg && (left_position != '0)
                      && (32'(right_position) <= 32'(item_count_reg))
                      && (left_position <= right_position);
        status.bld_empty = (run_count_reg == '0);
        status.bld_last  = (32'(k_reg) == LEVELS - 1)
                           && (32'(i_reg) + 1 == 32'(run_count_reg));
        status.out_free  = out_free;
    end

    // Append decode: run index and length of the run that the item joins.
    always_comb begin
        full     = (32'(item_count_reg) == MAX_ITEMS);
        new_run  = (item_count_reg == '0) || (value_reg != last_value_reg);
        run_idx  = new_run ? AW'(run_count_reg) : AW'(run_count_reg - CW'(1));
        len_next = new_run ? CW'(1) : run_len_reg + CW'(1);
    end

    // Build: partner entry half a window away.
    always_comb begin
        has_b  = (32'(i_reg) + (32'd1 << (32'(k_reg) - 1))) < 32'(run_count_reg);
        i_half = AW'(32'(i_reg) + (32'd1 << (32'(k_reg) - 1)));
    end

    // Query: sparse-table level for the whole runs between the edges.
    always_comb begin
        run_gap = ri_reg - li_reg - AW'(1);
        m_sel   = (floor_log2(run_gap) > LEVELS - 1) ? LW'(LEVELS - 1)
                                                     : LW'(floor_log2(run_gap));
    end

    // Memory addresses and write controls.
    always_comb begin
        rop_raddr = cmd.q_rd_r ? r_reg : l_reg;
        rs_raddr  = cmd.q_rd_rs2 ? li_reg + AW'(1) : rop_rdata;
        rop_we    = cmd.append && !full;
        rs_we     = cmd.append && !full && new_run;
        priority if (cmd.bld_rd_a) begin
            st_raddr = {k_reg - LW'(1), i_reg};
        end else if (cmd.bld_rd_b) begin
            st_raddr = {k_reg - LW'(1), i_half};
        end else if (cmd.q_rd_rs2) begin
            st_raddr = {m_sel, li_reg + AW'(1)};
        end else begin
            st_raddr = {m_reg, ri_reg - (AW'(1) << m_reg)};
        end
        if (cmd.bld_wr) begin
            st_we    = 1'b1;
            st_waddr = {k_reg, i_reg};
            st_wdata = (has_b && st_rdata > a_reg) ? st_rdata : a_reg;
        end else begin
            st_we    = cmd.append && !full;
            st_waddr = {LW'(0), run_idx};
            st_wdata = len_next;
        end
    end

    // Query result from edge runs and the two table reads.
    always_comb begin
        e_left  = '0;
        e_right = CW'(r_reg) - CW'(rs_reg) + CW'(1);
        mid     = (st_rdata > a_reg) ? st_rdata : a_reg;
        if (li_reg == ri_reg) begin
            best = CW'(r_reg) - CW'(l_reg) + CW'(1);
        end else if (li_reg + AW'(1) == ri_reg) begin
            e_left = CW'(rs_reg) - CW'(l_reg);
            best   = (e_left > e_right) ? e_left : e_right;
        end else begin
            e_left = CW'(rs2_reg) - CW'(l_reg);
            best   = (e_left > e_right) ? e_left : e_right;
            best   = (mid > best) ? mid : best;
        end
    end

    // Input latch and query capture registers.
    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            value_reg <= value;
            l_reg     <= AW'(left_position - POS_W'(1));
            r_reg     <= AW'(right_position - POS_W'(1));
        end
        if (cmd.q_rd_r) begin
            li_reg <= rop_rdata;
        end
        if (cmd.q_rd_rs) begin
            ri_reg <= rop_rdata;
        end
        if (cmd.q_rd_rs2) begin
            rs_reg <= rs_rdata;
            m_reg  <= m_sel;
        end
        if (cmd.q_rd_b) begin
            rs2_reg <= rs_rdata;
            a_reg   <= st_rdata;
        end
        if (cmd.bld_rd_b) begin
            a_reg <= st_rdata;
        end
        if (cmd.append && !full) begin
            last_value_reg <= value_reg;
            run_len_reg    <= len_next;
        end
    end

    // List counters, build counters and table flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            item_count_reg <= '0;
            run_count_reg  <= '0;
            built_reg      <= 1'b0;
            k_reg          <= '0;
            i_reg          <= '0;
        end else begin
            if (cmd.clear) begin
                item_count_reg <= '0;
                run_count_reg  <= '0;
                built_reg      <= 1'b0;
            end
            if (cmd.append && !full) begin
                item_count_reg <= item_count_reg + CW'(1);
                if (new_run) begin
                    run_count_reg <= run_count_reg + CW'(1);
                end
                built_reg <= 1'b0;
            end
            if (cmd.bld_init) begin
                k_reg <= LW'(1);
                i_reg <= '0;
            end
            if (cmd.bld_wr) begin
                if (32'(i_reg) + 1 == 32'(run_count_reg)) begin
                    i_reg <= '0;
                    k_reg <= k_reg + LW'(1);
                end else begin
                    i_reg <= i_reg + AW'(1);
                end
            end
            if (cmd.bld_done) begin
                built_reg <= 1'b1;
            end
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if ((cmd.q_out || cmd.q_invalid) && out_free) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if ((cmd.q_out || cmd.q_invalid) && out_free) begin
            freq_reg <= cmd.q_out ? FREQ_W'(best) : '0;
            inv_reg  <= cmd.q_invalid;
        end
    end

    assign m_tvalid      = m_tvalid_reg;
    assign max_frequency = freq_reg;
    assign invalid       = inv_reg;

    // Run index of each position.
    rmfs_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_run_of_pos (
        .aclk  (aclk),
        .we    (rop_we),
        .waddr (AW'(item_count_reg)),
        .wdata (run_idx),
        .raddr (rop_raddr),
        .rdata (rop_rdata)
    );

    // Start position of each run.
    rmfs_ram #(.WIDTH(AW), .DEPTH(MAX_ITEMS)) u_run_start (
        .aclk  (aclk),
        .we    (rs_we),
        .waddr (AW'(run_count_reg)),
        .wdata (AW'(item_count_reg)),
        .raddr (rs_raddr),
        .rdata (rs_rdata)
    );

    // Sparse table; level zero holds the run lengths.
    rmfs_ram #(.WIDTH(CW), .DEPTH(LEVELS << AW)) u_sparse (
        .aclk  (aclk),
        .we    (st_we),
        .waddr (st_waddr),
        .wdata (st_wdata),
        .raddr (st_raddr),
        .rdata (st_rdata)
    );

`ifndef ASSERT_OFF
    a_runs_le_items: assert property (@(posedge aclk) disable iff (!aresetn)
        run_count_reg <= item_count_reg)
        else $error("run count exceeds item count");
    a_items_le_max: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(item_count_reg) <= MAX_ITEMS)
        else $error("item count exceeds capacity");
    a_result_shown: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.q_out && out_free) |=> (m_tvalid_reg && !inv_reg))
        else $error("query result not presented");
    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && inv_reg) |-> (freq_reg == '0))
        else $error("invalid result carries a count");
`endif

endmodule
